// File: rtl/fire_permission_gate_core_macros.svh
// Assertion macros shared by the fire permission gate modules.
`ifndef FIRE_PERMISSION_GATE_CORE_MACROS_SVH
`define FIRE_PERMISSION_GATE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fpg_pkg.sv
// Package: types, constants and helpers of the fire permission gate.
`default_nettype none
package fpg_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [31:0] MIN_RANGE_SQ = 32'd10000;
    localparam logic [31:0] MAX_RANGE_SQ = 32'd225000000;
    localparam logic [20:0] SPIN_LIMIT   = 21'd2048;
    localparam logic [7:0]  LOCK_MAX     = 8'hFF;

    localparam int unsigned ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_NEAR_TOL    = 3'd0,
        REG_FAR_TOL     = 3'd1,
        REG_JUDGE_DIST  = 3'd2,
        REG_AUTO_FIRE   = 3'd3,
        REG_COOLDOWN    = 3'd4,
        REG_MIN_LOCK    = 3'd5,
        REG_MAX_STALE   = 3'd6,
        REG_MAX_RADIUS  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] near_tolerance;
        logic [15:0] far_tolerance;
        logic [14:0] judge_distance_mm;
        logic        auto_fire_enable;
        logic [23:0] cooldown_us;
        logic [7:0]  min_lock_frames;
        logic [23:0] max_stale_us;
        logic [14:0] max_radius_mm;
    } cfg_t;

    // Classified frame handed from front to back
    typedef struct packed {
        logic               gated;
        logic               on_target;
        logic               quiet;
        logic [15:0]        tol;
        logic signed [19:0] command_yaw;
        logic signed [19:0] gimbal_yaw;
        logic [31:0]        time_us;
    } entry_t;

    function automatic logic [20:0] mag21(input logic signed [20:0] v);
        logic [20:0] r;
        r = v[20] ? 21'(-v) : 21'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fpg_in_if.sv
// Interface: input frame channel.
`default_nettype none
interface fpg_in_if;
    logic               valid;
    logic               ready;
    logic               control_on;
    logic               target_present;
    logic signed [15:0] target_x_mm;
    logic signed [15:0] target_y_mm;
    logic               aim_valid;
    logic               track_diverged;
    logic signed [15:0] spin_speed;
    logic signed [15:0] radius_mm;
    logic signed [19:0] command_yaw;
    logic signed [19:0] gimbal_yaw;
    logic [31:0]        time_us;

    modport source (
        output valid, control_on, target_present, target_x_mm, target_y_mm, aim_valid,
               track_diverged, spin_speed, radius_mm, command_yaw, gimbal_yaw, time_us,
        input  ready
    );
    modport sink (
        input  valid, control_on, target_present, target_x_mm, target_y_mm, aim_valid,
               track_diverged, spin_speed, radius_mm, command_yaw, gimbal_yaw, time_us,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/fpg_out_if.sv
// Interface: fire decision channel.
`default_nettype none
interface fpg_out_if;
    logic valid;
    logic ready;
    logic fire;

    modport source (output valid, fire, input ready);
    modport sink (input valid, fire, output ready);
endinterface
`default_nettype wire

// File: rtl/fpg_cfg.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module fpg_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [fpg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output fpg_pkg::cfg_t                  cfg
);
    import fpg_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_tolerance    <= '0;
            cfg_reg.far_tolerance     <= '0;
            cfg_reg.judge_distance_mm <= '0;
            cfg_reg.auto_fire_enable  <= 1'b0;
            cfg_reg.cooldown_us       <= 24'd250000;
            cfg_reg.min_lock_frames   <= 8'd5;
            cfg_reg.max_stale_us      <= 24'd50000;
            cfg_reg.max_radius_mm     <= 15'd2000;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_NEAR_TOL:   cfg_reg.near_tolerance    <= pwdata[15:0];
                REG_FAR_TOL:    cfg_reg.far_tolerance     <= pwdata[15:0];
                REG_JUDGE_DIST: cfg_reg.judge_distance_mm <= pwdata[14:0];
                REG_AUTO_FIRE:  cfg_reg.auto_fire_enable  <= pwdata[0];
                REG_COOLDOWN:   cfg_reg.cooldown_us       <= pwdata[23:0];
                REG_MIN_LOCK:   cfg_reg.min_lock_frames   <= pwdata[7:0];
                REG_MAX_STALE:  cfg_reg.max_stale_us      <= pwdata[23:0];
                REG_MAX_RADIUS: cfg_reg.max_radius_mm     <= pwdata[14:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_NEAR_TOL:   prdata = {16'd0, cfg_reg.near_tolerance};
            REG_FAR_TOL:    prdata = {16'd0, cfg_reg.far_tolerance};
            REG_JUDGE_DIST: prdata = {17'd0, cfg_reg.judge_distance_mm};
            REG_AUTO_FIRE:  prdata = {31'd0, cfg_reg.auto_fire_enable};
            REG_COOLDOWN:   prdata = {8'd0, cfg_reg.cooldown_us};
            REG_MIN_LOCK:   prdata = {24'd0, cfg_reg.min_lock_frames};
            REG_MAX_STALE:  prdata = {8'd0, cfg_reg.max_stale_us};
            REG_MAX_RADIUS: prdata = {17'd0, cfg_reg.max_radius_mm};
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/fpg_front.sv
// Front end: accept frames, square the range, classify target and tolerance.
`default_nettype none
module fpg_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  fpg_pkg::cfg_t    cfg,
    fpg_in_if.sink           in_ch,
    output logic             push_valid,
    output fpg_pkg::entry_t  push_data,
    input  wire logic        push_ready
);
    import fpg_pkg::*;

    logic               a_valid_reg, a_valid_next;
    logic [30:0]        sq_x_reg, sq_y_reg;
    logic [29:0]        j2_reg;
    logic               gated_reg, aim_reg, div_reg, quiet_reg;
    logic signed [19:0] cmd_reg, gim_reg;
    logic [31:0]        time_reg;

    logic signed [31:0] px, py;
    logic [20:0]        rad_mag, spin_mag;
    logic               quiet_next, take;
    logic [31:0]        d2, j2_ext;
    logic               far;

    assign in_ch.ready = !a_valid_reg || push_ready;
    assign take        = in_ch.valid && in_ch.ready;

    assign px       = 32'(in_ch.target_x_mm) * 32'(in_ch.target_x_mm);
    assign py       = 32'(in_ch.target_y_mm) * 32'(in_ch.target_y_mm);
    assign rad_mag  = mag21(21'(in_ch.radius_mm));
    assign spin_mag = mag21(21'(in_ch.spin_speed));
    assign quiet_next = (rad_mag < {6'd0, cfg.max_radius_mm}) && (spin_mag < SPIN_LIMIT);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (take)
            a_valid_next = 1'b1;
        else if (push_ready)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        j2_reg <= 30'(cfg.judge_distance_mm) * 30'(cfg.judge_distance_mm);
        if (take)
        begin
            sq_x_reg  <= px[30:0];
            sq_y_reg  <= py[30:0];
            gated_reg <= !(in_ch.control_on && in_ch.target_present && cfg.auto_fire_enable);
            aim_reg   <= in_ch.aim_valid;
            div_reg   <= in_ch.track_diverged;
            quiet_reg <= quiet_next;
            cmd_reg   <= in_ch.command_yaw;
            gim_reg   <= in_ch.gimbal_yaw;
            time_reg  <= in_ch.time_us;
        end
    end

    assign d2     = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign j2_ext = {2'd0, j2_reg};
    assign far    = d2 > j2_ext;

    assign push_valid             = a_valid_reg;
    assign push_data.gated        = gated_reg;
    assign push_data.on_target    = aim_reg && !div_reg && (d2 > MIN_RANGE_SQ)
                                    && (d2 < MAX_RANGE_SQ);
    assign push_data.quiet        = quiet_reg;
    assign push_data.tol          = far ? cfg.far_tolerance : cfg.near_tolerance;
    assign push_data.command_yaw  = cmd_reg;
    assign push_data.gimbal_yaw   = gim_reg;
    assign push_data.time_us      = time_reg;

endmodule
`default_nettype wire

// File: rtl/fpg_queue.sv
// Short queue of classified words between front and back.
`default_nettype none
`include "fire_permission_gate_core_macros.svh"
module fpg_queue #(
    parameter int unsigned Depth = fpg_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    input  fpg_pkg::entry_t  push_data,
    output logic             push_ready,
    output logic             pop_valid,
    output fpg_pkg::entry_t  pop_data,
    input  wire logic        pop_ready
);
    import fpg_pkg::*;

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    entry_t            store_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              push, pop;

    assign push_ready = count_reg < CntW'(Depth);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    `FPG_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CntW'(Depth), "queue count beyond depth")
    `FPG_ASSERT_NEXT(a_push_lands, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule
`default_nettype wire

// File: rtl/fpg_back.sv
// Back end: apply state checks, update lock and stamps, register the decision.
`default_nettype none
`include "fire_permission_gate_core_macros.svh"
module fpg_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  fpg_pkg::cfg_t    cfg,
    input  wire logic        pop_valid,
    input  fpg_pkg::entry_t  pop_data,
    output logic             pop_ready,
    fpg_out_if.source        out_ch
);
    import fpg_pkg::*;

    logic signed [19:0] prev_cmd_reg, prev_cmd_next;
    logic [7:0]         lock_reg, lock_next;
    logic [31:0]        last_fire_reg, last_fire_next;
    logic [31:0]        last_valid_reg, last_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               fire_reg, fire_next;

    logic               pop;
    logic [31:0]        since_fire, since_valid;
    logic [20:0]        dc_mag, dg_mag;
    logic               cooled, fresh, stable, allow;
    logic [7:0]         lock_inc;

    assign pop_ready    = !out_valid_reg || out_ch.ready;
    assign pop          = pop_valid && pop_ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.fire  = fire_reg;

    assign since_fire  = pop_data.time_us - last_fire_reg;
    assign since_valid = pop_data.time_us - last_valid_reg;
    assign cooled      = since_fire >= {8'd0, cfg.cooldown_us};
    assign fresh       = (cfg.max_stale_us == '0) || (since_valid <= {8'd0, cfg.max_stale_us});
    assign dc_mag      = mag21(21'(prev_cmd_reg) - 21'(pop_data.command_yaw));
    assign dg_mag      = mag21(21'(pop_data.gimbal_yaw) - 21'(prev_cmd_reg));
    assign stable      = (dc_mag < {4'd0, pop_data.tol, 1'b0})
                         && (dg_mag < {5'd0, pop_data.tol});
    assign allow       = pop_data.on_target && fresh && stable && cooled
                         && pop_data.quiet;
    assign lock_inc    = (lock_reg == LOCK_MAX) ? lock_reg : lock_reg + 8'd1;

    always_comb
    begin
        prev_cmd_next   = prev_cmd_reg;
        lock_next       = lock_reg;
        last_fire_next  = last_fire_reg;
        last_valid_next = last_valid_reg;
        out_valid_next  = out_valid_reg;
        fire_next       = fire_reg;
        if (out_ch.ready)
            out_valid_next = 1'b0;
        if (pop)
        begin
            out_valid_next = 1'b1;
            fire_next      = 1'b0;
            if (!pop_data.gated)
            begin
                prev_cmd_next = pop_data.command_yaw;
                lock_next     = allow ? lock_inc : '0;
                if (pop_data.on_target)
                    last_valid_next = pop_data.time_us;
                if (allow && (lock_inc >= cfg.min_lock_frames))
                begin
                    fire_next      = 1'b1;
                    last_fire_next = pop_data.time_us;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cmd_reg   <= '0;
            lock_reg       <= '0;
            last_fire_reg  <= '0;
            last_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            fire_reg       <= 1'b0;
        end
        else
        begin
            prev_cmd_reg   <= prev_cmd_next;
            lock_reg       <= lock_next;
            last_fire_reg  <= last_fire_next;
            last_valid_reg <= last_valid_next;
            out_valid_reg  <= out_valid_next;
            fire_reg       <= fire_next;
        end
    end

    `FPG_ASSERT_NEXT(a_fire_locked, pop && fire_next, lock_reg != '0, "fire without lock")
    `FPG_ASSERT_NEXT(a_fire_stamp, pop && fire_next, last_fire_reg == $past(pop_data.time_us), "stamp missed")

endmodule
`default_nettype wire

// File: rtl/fire_permission_gate_core.sv
// Top level of the fire permission gate: config port, front, queue, back.
//
//  Channel  Role   Handshake               Payload
//  in_ch    sink   valid/ready             frame fields, control_on .. time_us
//  out_ch   source valid/ready             fire
//  apb      slave  psel/penable/pready     paddr[4:2] selects a 32-bit register
//
// One word per cycle sustained when no side stalls. The front registers the
// squares, the queue holds classified words, the back end updates lock and
// stamps and registers the decision; each word passes through them in turn.
// Either side may stall: the queue absorbs up to QUEUE_DEPTH words.
// rst_n clears control state and stamps asynchronously; no clearing pass.
`default_nettype none
module fire_permission_gate_core #(
    parameter int unsigned QueueDepth = fpg_pkg::QUEUE_DEPTH
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [fpg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    fpg_in_if.sink                         in_ch,
    fpg_out_if.source                      out_ch
);
    import fpg_pkg::*;

    cfg_t   cfg;
    logic   push_valid, push_ready, pop_valid, pop_ready;
    entry_t push_data, pop_data;

    fpg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    fpg_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    fpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for fire_permission_gate_core: directed and random frames.
module testbench;
    import fpg_pkg::*;

    localparam longint NEAR_LIMIT_SQ = 64'd10000;
    localparam longint FAR_LIMIT_SQ  = 64'd225000000;
    localparam longint SPIN_CEIL     = 64'd2048;
    localparam logic [7:0] LOCK_CEIL = 8'hFF;
    localparam int PHASES            = 8;
    localparam int WORDS_PER_PHASE   = 125;
    localparam int LONG_HOLD         = 300;
    localparam int CYCLE_LIMIT       = 400000;

    typedef struct {
        logic               control_on;
        logic               target_present;
        logic signed [15:0] target_x_mm;
        logic signed [15:0] target_y_mm;
        logic               aim_valid;
        logic               track_diverged;
        logic signed [15:0] spin_speed;
        logic signed [15:0] radius_mm;
        logic signed [19:0] command_yaw;
        logic signed [19:0] gimbal_yaw;
        logic [31:0]        time_us;
    } frame_t;

    typedef struct {
        logic [15:0] near_tol;
        logic [15:0] far_tol;
        logic [14:0] judge_mm;
        logic        fire_en;
        logic [23:0] cooldown_us;
        logic [7:0]  min_lock;
        logic [23:0] max_stale_us;
        logic [14:0] max_radius_mm;
    } gate_cfg_t;

    typedef struct {
        bit        is_cfg;
        gate_cfg_t cfg;
        frame_t    f;
        bit        typed;
        logic      fire;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    fpg_in_if  in_ch();
    fpg_out_if out_ch();

    fire_permission_gate_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    gate_cfg_t          cfg;
    logic signed [19:0] prev_cmd_yaw;
    logic [7:0]         lock_run;
    logic [31:0]        last_shot_us;
    logic [31:0]        last_seen_us;

    logic      fire_due[$];
    plan_row_t plan[$];
    int        errors;
    int        cycles;
    bit        idle_on;
    int        hold_req;
    int        hold_seen;
    int        hold_left;
    int        yaw_base;
    logic [31:0] clock_us;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[fire_permission_gate_core] ERROR");
            $finish;
        end
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic decide_fire(input frame_t f);
        longint      dist_sq;
        longint      judge_sq;
        longint      tol;
        logic [31:0] since_shot;
        logic [31:0] since_seen;
        logic        on_target;
        logic        fresh;
        logic        cooled;
        logic        steady;
        logic        quiet;
        logic        allow;
        if (!f.control_on || !f.target_present || !cfg.fire_en)
            return 1'b0;
        dist_sq = longint'(f.target_x_mm) * longint'(f.target_x_mm)
                + longint'(f.target_y_mm) * longint'(f.target_y_mm);
        judge_sq = longint'(cfg.judge_mm) * longint'(cfg.judge_mm);
        tol = (dist_sq > judge_sq) ? longint'(cfg.far_tol) : longint'(cfg.near_tol);
        since_shot = f.time_us - last_shot_us;
        since_seen = f.time_us - last_seen_us;
        cooled = since_shot >= {8'd0, cfg.cooldown_us};
        on_target = f.aim_valid && dist_sq > NEAR_LIMIT_SQ && dist_sq < FAR_LIMIT_SQ
                    && !f.track_diverged;
        fresh = (cfg.max_stale_us == 24'd0) || (since_seen <= {8'd0, cfg.max_stale_us});
        steady = magnitude(longint'(prev_cmd_yaw) - longint'(f.command_yaw)) < 2 * tol
                 && magnitude(longint'(f.gimbal_yaw) - longint'(prev_cmd_yaw)) < tol;
        if (on_target)
            last_seen_us = f.time_us;
        quiet = magnitude(longint'(f.radius_mm)) < longint'(cfg.max_radius_mm)
                && magnitude(longint'(f.spin_speed)) < SPIN_CEIL;
        allow = on_target && fresh && steady && cooled && quiet;
        if (allow)
        begin
            if (lock_run != LOCK_CEIL)
                lock_run++;
        end
        else
            lock_run = 8'd0;
        prev_cmd_yaw = f.command_yaw;
        if (allow && lock_run >= cfg.min_lock)
        begin
            last_shot_us = f.time_us;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] reg_value(input gate_cfg_t c, input reg_idx_t idx);
        case (idx)
            REG_NEAR_TOL:   return 32'(c.near_tol);
            REG_FAR_TOL:    return 32'(c.far_tol);
            REG_JUDGE_DIST: return 32'(c.judge_mm);
            REG_AUTO_FIRE:  return 32'(c.fire_en);
            REG_COOLDOWN:   return 32'(c.cooldown_us);
            REG_MIN_LOCK:   return 32'(c.min_lock);
            REG_MAX_STALE:  return 32'(c.max_stale_us);
            REG_MAX_RADIUS: return 32'(c.max_radius_mm);
            default:        return 32'd0;
        endcase
    endfunction

    function automatic gate_cfg_t random_cfg();
        gate_cfg_t c;
        c.near_tol      = 16'($urandom_range(60, 3000));
        c.far_tol       = 16'($urandom_range(60, 1500));
        c.judge_mm      = 15'($urandom_range(0, 32767));
        c.fire_en       = ($urandom_range(0, 7) != 0);
        c.cooldown_us   = 24'($urandom_range(0, 40000));
        c.min_lock      = 8'($urandom_range(0, 6));
        c.max_stale_us  = ($urandom_range(0, 2) == 0) ? 24'd0
                                                       : 24'($urandom_range(10000, 100000));
        c.max_radius_mm = 15'($urandom_range(500, 32767));
        return c;
    endfunction

    function automatic frame_t good(input int x, input int cmd, input int gim,
                                    input logic [31:0] t);
        frame_t f;
        f.control_on     = 1'b1;
        f.target_present = 1'b1;
        f.target_x_mm    = 16'(x);
        f.target_y_mm    = 16'sd0;
        f.aim_valid      = 1'b1;
        f.track_diverged = 1'b0;
        f.spin_speed     = 16'sd0;
        f.radius_mm      = 16'sd0;
        f.command_yaw    = 20'(cmd);
        f.gimbal_yaw     = 20'(gim);
        f.time_us        = t;
        return f;
    endfunction

    function automatic frame_t make_frame(input bit noisy);
        frame_t f;
        int     cmd;
        if (noisy)
        begin
            f.control_on     = 1'($urandom);
            f.target_present = 1'($urandom);
            f.target_x_mm    = 16'($urandom);
            f.target_y_mm    = 16'($urandom);
            f.aim_valid      = 1'($urandom);
            f.track_diverged = 1'($urandom);
            f.spin_speed     = 16'($urandom);
            f.radius_mm      = 16'($urandom);
            f.command_yaw    = 20'($urandom);
            f.gimbal_yaw     = 20'($urandom);
            f.time_us        = $urandom;
            return f;
        end
        yaw_base = yaw_base + int'($urandom_range(0, 20)) - 10;
        if (yaw_base > 500000 || yaw_base < -500000)
            yaw_base = 0;
        if ($urandom_range(0, 39) == 0)
            clock_us = clock_us + $urandom_range(50000, 2000000);
        else
            clock_us = clock_us + $urandom_range(200, 15000);
        cmd = yaw_base + int'($urandom_range(0, 40)) - 20;
        f.control_on     = ($urandom_range(0, 19) != 0);
        f.target_present = ($urandom_range(0, 19) != 0);
        f.target_x_mm    = 16'(int'($urandom_range(0, 20000)) - 10000);
        f.target_y_mm    = 16'(int'($urandom_range(0, 20000)) - 10000);
        f.aim_valid      = ($urandom_range(0, 19) != 0);
        f.track_diverged = ($urandom_range(0, 29) == 0);
        f.spin_speed     = 16'(int'($urandom_range(0, 5000)) - 2500);
        f.radius_mm      = 16'(int'($urandom_range(0, 6000)) - 3000);
        f.command_yaw    = 20'(cmd);
        f.gimbal_yaw     = 20'(cmd + int'($urandom_range(0, 60)) - 30);
        f.time_us        = clock_us;
        return f;
    endfunction

    function automatic void add_row(input frame_t f, input bit typed, input logic fire);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.f      = f;
        r.typed  = typed;
        r.fire   = fire;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(input gate_cfg_t c);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.cfg    = c;
        r.typed  = 1'b0;
        r.fire   = 1'b0;
        plan.push_back(r);
    endfunction

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (fire_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input gate_cfg_t c);
        reg_idx_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = reg_idx_t'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= reg_value(c, idx);
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        // read every register back
        for (int i = 0; i < 8; i++)
        begin
            idx = reg_idx_t'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== reg_value(c, idx))
            begin
                $error("prdata mismatch at register %0d: expected %0h, actual %0h",
                       i, reg_value(c, idx), prdata);
                errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg = c;
    endtask

    task automatic send_frame(input frame_t f, input bit typed, input logic typed_fire);
        int   gap;
        logic predicted;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0)
            gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.control_on     <= f.control_on;
        in_ch.target_present <= f.target_present;
        in_ch.target_x_mm    <= f.target_x_mm;
        in_ch.target_y_mm    <= f.target_y_mm;
        in_ch.aim_valid      <= f.aim_valid;
        in_ch.track_diverged <= f.track_diverged;
        in_ch.spin_speed     <= f.spin_speed;
        in_ch.radius_mm      <= f.radius_mm;
        in_ch.command_yaw    <= f.command_yaw;
        in_ch.gimbal_yaw     <= f.gimbal_yaw;
        in_ch.time_us        <= f.time_us;
        in_ch.valid          <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = decide_fire(f);
        fire_due.push_back(typed ? typed_fire : predicted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            hold_left = gap_len() - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (fire_due.size() == 0)
            begin
                $error("unexpected word: fire=%0b", out_ch.fire);
                errors++;
            end
            else
            begin
                want = fire_due.pop_front();
                if (out_ch.fire !== want)
                begin
                    $error("fire mismatch: expected %0b, actual %0b", want, out_ch.fire);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        frame_t    f;
        gate_cfg_t c;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.control_on     = 1'b0;
        in_ch.target_present = 1'b0;
        in_ch.target_x_mm    = '0;
        in_ch.target_y_mm    = '0;
        in_ch.aim_valid      = 1'b0;
        in_ch.track_diverged = 1'b0;
        in_ch.spin_speed     = '0;
        in_ch.radius_mm      = '0;
        in_ch.command_yaw    = '0;
        in_ch.gimbal_yaw     = '0;
        in_ch.time_us        = '0;
        out_ch.ready         = 1'b0;
        errors       = 0;
        cycles       = 0;
        idle_on      = 1'b1;
        hold_req     = 0;
        hold_seen    = 0;
        yaw_base     = 0;
        clock_us     = '0;
        cfg          = '{16'd0, 16'd0, 15'd0, 1'b0, 24'd250000, 8'd5, 24'd50000, 15'd2000};
        prev_cmd_yaw = '0;
        lock_run     = '0;
        last_shot_us = '0;
        last_seen_us = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // firing disabled after reset: field extremes give no fire
        f = good(32767, 524287, 524287, 32'hFFFF_FFFF);
        f.target_y_mm    = 16'sd32767;
        f.track_diverged = 1'b1;
        f.spin_speed     = 16'sd32767;
        f.radius_mm      = 16'sd32767;
        add_row(f, 1'b1, 1'b0);
        f = good(-32768, -524288, -524288, 32'd0);
        f.target_y_mm = -16'sd32768;
        f.aim_valid   = 1'b0;
        f.spin_speed  = -16'sd32768;
        f.radius_mm   = -16'sd32768;
        add_row(f, 1'b1, 1'b0);

        c = '{16'd400, 16'd200, 15'd3000, 1'b1, 24'd1000, 8'd2, 24'd50000, 15'd2000};
        add_cfg(c);
        add_row(good(1000, 0, 0, 32'd10000), 1'b0, 1'b0);
        add_row(good(1000, 0, 0, 32'd12000), 1'b0, 1'b0);
        add_row(good(1000, 0, 0, 32'd12500), 1'b1, 1'b0);
        f = good(1000, 0, 0, 32'd20000);
        f.control_on = 1'b0;
        add_row(f, 1'b1, 1'b0);
        f = good(1000, 0, 0, 32'd21000);
        f.target_present = 1'b0;
        add_row(f, 1'b1, 1'b0);
        add_row(good(100, 0, 0, 32'd22000), 1'b1, 1'b0);
        add_row(good(15000, 0, 0, 32'd23000), 1'b1, 1'b0);
        f = good(-32768, 0, 0, 32'd24000);
        f.target_y_mm = -16'sd32768;
        add_row(f, 1'b1, 1'b0);
        f = good(1000, 0, 0, 32'd25000);
        f.aim_valid = 1'b0;
        add_row(f, 1'b1, 1'b0);
        f = good(1000, 0, 0, 32'd26000);
        f.track_diverged = 1'b1;
        add_row(f, 1'b1, 1'b0);
        f = good(1000, 0, 0, 32'd27000);
        f.spin_speed = 16'sd2048;
        add_row(f, 1'b1, 1'b0);
        f = good(1000, 0, 0, 32'd28000);
        f.spin_speed = -16'sd2047;
        add_row(f, 1'b0, 1'b0);
        f = good(1000, 0, 0, 32'd29000);
        f.radius_mm = -16'sd2000;
        add_row(f, 1'b1, 1'b0);
        f = good(1000, 0, 0, 32'd30000);
        f.radius_mm = 16'sd1999;
        add_row(f, 1'b0, 1'b0);
        add_row(good(5000, 0, 199, 32'd31000), 1'b0, 1'b0);
        add_row(good(5000, 0, 200, 32'd32000), 1'b1, 1'b0);
        add_row(good(1000, 800, 0, 32'd33000), 1'b1, 1'b0);
        add_row(good(1000, 800, 800, 32'd83001), 1'b1, 1'b0);
        add_row(good(1000, 800, 800, 32'd83002), 1'b0, 1'b0);

        // zero tolerance never steady; freshness off; fire on first permitted frame
        c = '{16'd0, 16'd200, 15'd3000, 1'b1, 24'd1000, 8'd0, 24'd0, 15'd2000};
        add_cfg(c);
        add_row(good(1000, 800, 800, 32'd100000000), 1'b1, 1'b0);
        c.near_tol = 16'd400;
        add_cfg(c);
        add_row(good(1000, 800, 800, 32'hFFFF_FF00), 1'b0, 1'b0);
        add_row(good(1000, 800, 800, 32'h0000_0100), 1'b1, 1'b0);
        add_row(good(1000, 800, 800, 32'h0000_0400), 1'b0, 1'b0);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_cfg(plan[i].cfg);
            end
            else
                send_frame(plan[i].f, plan[i].typed, plan[i].fire);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: c = '{16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1, 24'hFFFFFF, 8'hFF, 24'hFFFFFF,
                         15'h7FFF};
                1: c = '{16'd0, 16'd0, 15'd0, 1'b0, 24'd0, 8'd0, 24'd0, 15'd0};
                2: c = '{16'd0, 16'd0, 15'd0, 1'b1, 24'd0, 8'd0, 24'd0, 15'd0};
                default: c = random_cfg();
            endcase
            write_cfg(c);
            idle_on  = (p % 3 != 2);
            clock_us = $urandom;
            yaw_base = int'($urandom_range(0, 800000)) - 400000;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // hold the output off long enough to back up the input
                if (p == 4 && n == 10)
                    hold_req++;
                // drop the input until every word is out
                if (p == 6 && n == 50)
                    settle();
                send_frame(make_frame($urandom_range(0, 99) < 15), 1'b0, 1'b0);
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[fire_permission_gate_core] OK");
        else
            $display("[fire_permission_gate_core] ERROR");
        $finish;
    end
endmodule
